// ===== rtl/core/erqm_pkg.sv =====
// Shared codes and constants for the epoch round-robin queue merger.
package erqm_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned QueueW  = 3;
  localparam int unsigned TxnW    = 64;
  localparam int unsigned EpochW  = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 4;
  localparam int unsigned CountW  = 4;
  localparam int unsigned EntryW  = TxnW + 1;

  localparam logic [FuncW-1:0] FUNC_PUSH_TXN    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_PUSH_MARKER = 2'd1;
  localparam logic [FuncW-1:0] FUNC_DEQUEUE     = 2'd2;

  localparam logic [StatusW-1:0] ST_EMPTY   = 3'd0;
  localparam logic [StatusW-1:0] ST_DELIVER = 3'd1;
  localparam logic [StatusW-1:0] ST_MARKER  = 3'd2;
  localparam logic [StatusW-1:0] ST_ACCEPT  = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_NODE_COUNT = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_NODE = 4'd1;

endpackage

// ===== rtl/core/erqm_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module erqm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/epoch_round_robin_queue_merger_core.sv =====
// Top level of the epoch round-robin queue merger: per-node circular queues in one RAM.
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   command   | start_i, busy_o, func/source_queue/txn_i  | in
//   config    | cfg_valid_i, cfg_ready_o, cfg_index/data  | in
//   result    | result_valid_o, status/out_txn/return/... | out
//
// Each command is accepted while busy_o is low: in the accept cycle the head and tail
// pointers are read and updated and the entry RAM is written or read; in the next cycle
// the RAM read data returns, the result beat is shown and the serve pointer and epoch are
// updated. busy_o is high in that cycle, so no new command is taken while a result is shown.
// Reset clears pointers, serve pointer, epoch and registers, sets the node count to 1,
// and leaves the entry RAM uncleared. The result beat cannot be stalled by the receiver.
module epoch_round_robin_queue_merger_core
  import erqm_pkg::*;
#(
  parameter int unsigned MAX_NODES   = 8,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [FuncW-1:0]     func_i,
  input  logic [QueueW-1:0]    source_queue_i,
  input  logic [TxnW-1:0]      txn_word_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDatW-1:0]   cfg_data_i,
  output logic                 result_valid_o,
  output logic [StatusW-1:0]   status_o,
  output logic [TxnW-1:0]      out_txn_o,
  output logic [QueueW-1:0]    return_node_o,
  output logic                 return_valid_o,
  output logic                 epoch_advanced_o,
  output logic [EpochW-1:0]    epoch_count_o
);

  localparam int unsigned NodeW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned RamD   = MAX_NODES * QUEUE_DEPTH;
  localparam int unsigned AddrW  = $clog2(RamD);
  localparam int unsigned CmpW   = 8;

  logic [PtrW-1:0]    heads_q [MAX_NODES];
  logic [PtrW-1:0]    tails_q [MAX_NODES];
  logic [NodeW-1:0]   serve_q, serve_d;
  logic [EpochW-1:0]  epoch_q, epoch_d;
  logic [CountW-1:0]  node_count_q;
  logic [QueueW-1:0]  local_node_q;
  logic               busy_q;
  logic               deq_q;
  logic [StatusW-1:0] res_st_q, res_st_d;

  logic               accept;
  logic               is_push, is_marker_push, is_deq;
  logic               q_in_range;
  logic [NodeW-1:0]   q_idx, ptr_idx;
  logic [PtrW-1:0]    head_rd, tail_rd, ptr_sel, ptr_next, tail_next;
  logic               full, nonempty;
  logic               push_ok, deq_ok;
  logic               ram_we;
  logic [AddrW-1:0]   ram_addr;
  logic [EntryW-1:0]  ram_wdata, ram_rdata;

  logic [CmpW-1:0]    eff_count;
  logic               entry_marker;
  logic               wrap;

  assign accept         = start_i && !busy_q;
  assign busy_o         = busy_q;
  assign cfg_ready_o    = 1'b1;
  assign is_push        = (func_i == FUNC_PUSH_TXN) || (func_i == FUNC_PUSH_MARKER);
  assign is_marker_push = (func_i == FUNC_PUSH_MARKER);
  assign is_deq         = (func_i == FUNC_DEQUEUE);
  assign q_in_range     = CmpW'(source_queue_i) < CmpW'(MAX_NODES);
  assign q_idx          = NodeW'(source_queue_i);
  assign ptr_idx        = is_push ? q_idx : serve_q;
  assign head_rd        = heads_q[ptr_idx];
  assign tail_rd        = tails_q[ptr_idx];
  assign ptr_sel        = is_push ? tail_rd : head_rd;
  assign ptr_next       = (PtrW'(QUEUE_DEPTH - 1) == ptr_sel) ? '0 : ptr_sel + PtrW'(1);
  assign tail_next      = ptr_next;
  assign full           = (tail_next == head_rd);
  assign nonempty       = (head_rd != tail_rd);
  assign push_ok        = accept && is_push && q_in_range && !full;
  assign deq_ok         = accept && is_deq && nonempty;

  assign ram_we    = push_ok;
  assign ram_addr  = AddrW'(ptr_idx) * AddrW'(QUEUE_DEPTH) + AddrW'(ptr_sel);
  assign ram_wdata = {is_marker_push, is_marker_push ? '0 : txn_word_i};

  erqm_ram #(
    .WIDTH(EntryW),
    .DEPTH(RamD)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    res_st_d = ST_EMPTY;
    unique case (func_i) inside
      FUNC_PUSH_TXN, FUNC_PUSH_MARKER: begin
        res_st_d = (q_in_range && !full) ? ST_ACCEPT : ST_FULL;
      end
      default: begin
        res_st_d = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    if (node_count_q == '0) begin
      eff_count = CmpW'(1);
    end else if (CmpW'(node_count_q) > CmpW'(MAX_NODES)) begin
      eff_count = CmpW'(MAX_NODES);
    end else begin
      eff_count = CmpW'(node_count_q);
    end
  end

  assign entry_marker = ram_rdata[EntryW-1];
  assign wrap         = (CmpW'(serve_q) + CmpW'(1)) >= eff_count;

  always_comb begin
    serve_d = serve_q;
    epoch_d = epoch_q;
    if (busy_q && deq_q && entry_marker) begin
      if (wrap) begin
        serve_d = '0;
        epoch_d = epoch_q + EpochW'(1);
      end else begin
        serve_d = serve_q + NodeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      deq_q        <= 1'b0;
      res_st_q     <= ST_EMPTY;
      serve_q      <= '0;
      epoch_q      <= '0;
      node_count_q <= CountW'(1);
      local_node_q <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        heads_q[i] <= '0;
        tails_q[i] <= '0;
      end
    end else begin
      busy_q  <= accept;
      serve_q <= serve_d;
      epoch_q <= epoch_d;
      if (accept) begin
        deq_q    <= deq_ok;
        res_st_q <= res_st_d;
      end
      if (push_ok) begin
        tails_q[ptr_idx] <= tail_next;
      end
      if (deq_ok) begin
        heads_q[ptr_idx] <= ptr_next;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_NODE_COUNT: node_count_q <= cfg_data_i;
          CFG_LOCAL_NODE: local_node_q <= cfg_data_i[QueueW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    result_valid_o   = busy_q;
    status_o         = res_st_q;
    out_txn_o        = '0;
    return_node_o    = '0;
    return_valid_o   = 1'b0;
    epoch_advanced_o = 1'b0;
    epoch_count_o    = epoch_d;
    if (deq_q) begin
      if (entry_marker) begin
        status_o         = ST_MARKER;
        epoch_advanced_o = wrap;
      end else begin
        status_o       = ST_DELIVER;
        out_txn_o      = ram_rdata[TxnW-1:0];
        return_node_o  = QueueW'(serve_q);
        return_valid_o = CmpW'(serve_q) != CmpW'(local_node_q);
      end
    end
  end

endmodule

// ===== test/epoch_round_robin_queue_merger_core_tb.sv =====
// Self-checking testbench for the epoch round-robin queue merger core.
`timescale 1ns / 1ps

module epoch_round_robin_queue_merger_core_tb;
  import erqm_pkg::*;

  localparam int unsigned Nodes       = 8;
  localparam int unsigned Depth       = 64;
  localparam int unsigned PtrW        = 6;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 1050;
  localparam int unsigned Phases      = 8;

  localparam logic [FuncW-1:0]   FUNC_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE   = 4'd2;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [QueueW-1:0] src;
    logic [TxnW-1:0]   word;
  } command_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TxnW-1:0]    txn;
    logic [QueueW-1:0]  node;
    logic               remote;
    logic               closed;
    logic [EpochW-1:0]  epoch;
  } merge_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [FuncW-1:0]    func_i;
  logic [QueueW-1:0]   source_queue_i;
  logic [TxnW-1:0]     txn_word_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDatW-1:0]  cfg_data_i;
  logic                result_valid_o;
  logic [StatusW-1:0]  status_o;
  logic [TxnW-1:0]     out_txn_o;
  logic [QueueW-1:0]   return_node_o;
  logic                return_valid_o;
  logic                epoch_advanced_o;
  logic [EpochW-1:0]   epoch_count_o;

  epoch_round_robin_queue_merger_core #(
    .MAX_NODES  (Nodes),
    .QUEUE_DEPTH(Depth)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .source_queue_i  (source_queue_i),
    .txn_word_i      (txn_word_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .out_txn_o       (out_txn_o),
    .return_node_o   (return_node_o),
    .return_valid_o  (return_valid_o),
    .epoch_advanced_o(epoch_advanced_o),
    .epoch_count_o   (epoch_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  logic [TxnW-1:0]    slot_word   [Nodes][Depth];
  logic               slot_marker [Nodes][Depth];
  logic [PtrW-1:0]    head_ptr    [Nodes];
  logic [PtrW-1:0]    tail_ptr    [Nodes];
  logic [QueueW-1:0]  serve_q;
  logic [EpochW-1:0]  epoch_num;
  logic [CountW-1:0]  cfg_nodes;
  logic [QueueW-1:0]  cfg_local;

  command_t           pending[$];
  merge_result_t      results_due[$];
  int unsigned        queued_items;
  int unsigned        bad_beats;
  int unsigned        cycles;
  bit                 steady;

  function automatic int unsigned served_nodes();
    if (cfg_nodes == 0) return 1;
    if (cfg_nodes > Nodes) return Nodes;
    return cfg_nodes;
  endfunction

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    return (p == Depth - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic merge_result_t merge_step(input command_t c);
    merge_result_t r;
    logic [PtrW-1:0] nt;
    logic [PtrW-1:0] h;
    r = '0;
    r.status = ST_EMPTY;
    if (c.func == FUNC_PUSH_TXN || c.func == FUNC_PUSH_MARKER) begin
      nt = next_slot(tail_ptr[c.src]);
      if (nt == head_ptr[c.src]) begin
        r.status = ST_FULL;
      end else begin
        slot_marker[c.src][tail_ptr[c.src]] = (c.func == FUNC_PUSH_MARKER);
        slot_word[c.src][tail_ptr[c.src]] = (c.func == FUNC_PUSH_MARKER) ? '0 : c.word;
        tail_ptr[c.src] = nt;
        r.status = ST_ACCEPT;
      end
    end else if (c.func == FUNC_DEQUEUE && head_ptr[serve_q] != tail_ptr[serve_q]) begin
      h = head_ptr[serve_q];
      head_ptr[serve_q] = next_slot(h);
      if (slot_marker[serve_q][h]) begin
        r.status = ST_MARKER;
        if (serve_q + 4'd1 >= served_nodes()) begin
          serve_q = '0;
          epoch_num = epoch_num + 1'b1;
          r.closed = 1'b1;
        end else begin
          serve_q = serve_q + 1'b1;
        end
      end else begin
        r.status = ST_DELIVER;
        r.txn = slot_word[serve_q][h];
        r.node = serve_q;
        r.remote = (serve_q != cfg_local);
      end
    end
    r.epoch = epoch_num;
    return r;
  endfunction

  function automatic logic [TxnW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_cmd(input logic [FuncW-1:0] f, input logic [QueueW-1:0] q,
                           input logic [TxnW-1:0] w);
    pending.push_back({f, q, w});
    queued_items++;
  endtask

  task automatic add_fill(input logic [QueueW-1:0] q);
    int unsigned n;
    n = $urandom_range(64, 70);
    repeat (n) begin
      queue_cmd(($urandom_range(0, 9) == 0) ? FUNC_PUSH_MARKER : FUNC_PUSH_TXN, q, rand_word());
    end
  endtask

  task automatic settle();
    while (pending.size() != 0 || results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    repeat ($urandom_range(0, 2)) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NODE_COUNT: cfg_nodes = val[CountW-1:0];
      CFG_LOCAL_NODE: cfg_local = val[QueueW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report(input string what, input merge_result_t want, input merge_result_t got);
    bad_beats++;
    if (bad_beats <= 10) begin
      $display("%s: want status %0d txn %h node %0d remote %0b closed %0b epoch %0d", what,
               want.status, want.txn, want.node, want.remote, want.closed, want.epoch);
      $display("  got status %0d txn %h node %0d remote %0b closed %0b epoch %0d",
               got.status, got.txn, got.node, got.remote, got.closed, got.epoch);
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni || pending.size() == 0 || (!steady && $urandom_range(0, 99) < 21)) begin
      start_i <= 1'b0;
    end else begin
      start_i <= 1'b1;
      {func_i, source_queue_i, txn_word_i} <= pending[0];
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) pending.delete(0);
  end

  always @(posedge clk_i) begin : monitor
    merge_result_t got;
    merge_result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        got = {status_o, out_txn_o, return_node_o, return_valid_o, epoch_advanced_o,
               epoch_count_o};
        if (results_due.size() == 0) begin
          report("unexpected result beat", '0, got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) report("result mismatch", want, got);
        end
      end
      if (start_i && !busy_o) begin
        results_due.push_back(merge_step({func_i, source_queue_i, txn_word_i}));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [CountW-1:0] count_plan [Phases];
    int unsigned eff;
    int unsigned k;
    int unsigned pushes;
    int unsigned deqs;
    int unsigned extra;
    int unsigned roll;
    int unsigned phase_end;

    count_plan = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5, 4'd2, 4'd7};
    count_plan[Phases-1] = $urandom_range(0, 15);
    for (int q = 0; q < Nodes; q++) begin
      head_ptr[q] = '0;
      tail_ptr[q] = '0;
    end
    serve_q      = '0;
    epoch_num    = '0;
    cfg_nodes    = 4'd1;
    cfg_local    = '0;
    queued_items = 0;
    bad_beats    = 0;
    cycles       = 0;
    steady       = 1'b0;

    rst_ni         = 1'b0;
    start_i        = 1'b0;
    func_i         = FUNC_PUSH_TXN;
    source_queue_i = '0;
    txn_word_i     = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_NODE_COUNT;
    cfg_data_i     = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue, unused function code, extreme words, a push to an unserved queue.
    queue_cmd(FUNC_DEQUEUE, 3'd0, '0);
    queue_cmd(FUNC_UNUSED, $urandom_range(0, 7), rand_word());
    queue_cmd(FUNC_PUSH_TXN, 3'd0, '1);
    queue_cmd(FUNC_PUSH_TXN, 3'd0, '0);
    queue_cmd(FUNC_PUSH_MARKER, 3'd0, rand_word());
    queue_cmd(FUNC_PUSH_TXN, 3'd7, 64'h8000_0000_0000_0001);
    repeat (4) queue_cmd(FUNC_DEQUEUE, $urandom_range(0, 7), rand_word());
    settle();

    write_reg(CFG_NODE_COUNT, 4'd2);
    write_reg(CFG_LOCAL_NODE, 4'd1);
    queue_cmd(FUNC_PUSH_TXN, 3'd1, 64'h5555_5555_5555_5555);
    queue_cmd(FUNC_PUSH_MARKER, 3'd0, '1);
    queue_cmd(FUNC_PUSH_MARKER, 3'd1, '0);
    repeat (3) queue_cmd(FUNC_DEQUEUE, 3'd7, '1);
    queue_cmd(FUNC_PUSH_MARKER, 3'd0, rand_word());
    queue_cmd(FUNC_PUSH_TXN, 3'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_cmd(FUNC_DEQUEUE, 3'd0, '0);
    settle();

    // The serve pointer now sits beyond the served range.
    write_reg(CFG_NODE_COUNT, 4'd0);
    write_reg(CFG_LOCAL_NODE, 4'd3);
    write_reg(CFG_SPARE, $urandom_range(0, 15));
    queue_cmd(FUNC_DEQUEUE, 3'd5, rand_word());
    queue_cmd(FUNC_PUSH_MARKER, 3'd1, rand_word());
    queue_cmd(FUNC_DEQUEUE, 3'd2, rand_word());
    settle();

    for (int p = 0; p < Phases; p++) begin
      write_reg(CFG_NODE_COUNT, count_plan[p]);
      write_reg(CFG_LOCAL_NODE, (p == 0) ? 4'd7 : (p == 1) ? 4'd0 : $urandom_range(0, 7));
      steady = (p == 3);
      phase_end = queued_items + RandomItems / Phases;
      if (p == 1) begin
        add_fill(3'd0);
        repeat (70) queue_cmd(FUNC_DEQUEUE, $urandom_range(0, 7), rand_word());
      end
      while (queued_items < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          eff = served_nodes();
          pushes = 0;
          deqs = 0;
          for (int q = 0; q < eff; q++) begin
            k = $urandom_range(0, 3);
            for (int j = 0; j <= k; j++) begin
              if ($urandom_range(0, 9) < 3) begin
                queue_cmd(FUNC_DEQUEUE, $urandom_range(0, 7), rand_word());
                deqs++;
              end
              queue_cmd((j == k) ? FUNC_PUSH_MARKER : FUNC_PUSH_TXN, q, rand_word());
              pushes++;
            end
          end
          if ($urandom_range(0, 3) == 0) begin
            queue_cmd(FUNC_PUSH_TXN, $urandom_range(0, 7), rand_word());
            pushes++;
          end
          extra = $urandom_range(0, 2);
          while (deqs < pushes + extra) begin
            queue_cmd(FUNC_DEQUEUE, $urandom_range(0, 7), rand_word());
            deqs++;
          end
        end else if (roll < 96) begin
          repeat ($urandom_range(1, 6)) begin
            queue_cmd($urandom_range(0, 3), $urandom_range(0, 7), rand_word());
          end
        end else begin
          add_fill($urandom_range(0, 7));
        end
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (bad_beats == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/erqm_pkg.sv
rtl/core/erqm_ram.sv
rtl/core/epoch_round_robin_queue_merger_core.sv
test/epoch_round_robin_queue_merger_core_tb.sv
